/* rtl/gmsd_pkg.sv */
// Shared constants, codes and field layout for the grid mass-shift derivative block.
package gmsd_pkg;

	localparam int MAX_CELLS_DEF = 1024;

	// Item kinds carried on the input tuser.
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_CONN = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_CELL_COUNT = 1'b0;
	localparam logic CFG_INV_WIDTH  = 1'b1;

	localparam logic [10:0] CELL_COUNT_RST = 11'd1024;
	localparam logic [31:0] INV_WIDTH_RST  = 32'd65536;

	// 0.0001 in unsigned Q0.32.
	localparam logic [18:0] TENTH_MILLI = 19'd429497;

	localparam int MUL_W      = 33;
	localparam int DIVIDEND_W = 32;
	localparam int DER_W      = 48;

	localparam int IN_W  = 200;
	localparam int OUT_W = 64;

	// Input tdata field offsets, lowest bit first.
	localparam int OFS_IDX   = 0;
	localparam int OFS_MASS  = 10;
	localparam int OFS_VOLT  = 35;
	localparam int OFS_RATE  = 67;
	localparam int OFS_COND  = 99;
	localparam int OFS_EFF   = 100;
	localparam int OFS_REST  = 132;
	localparam int OFS_G     = 164;

endpackage

/* rtl/grid_mass_shift_derivative.sv */
// Top level of the grid mass-shift derivative block: sequencer, stores and datapath.
//
// Input items arrive on the s_t* channel, kind on s_tuser. A load item writes one
// cell's mass and voltage and clears its derivative in the cycle it is accepted.
// A read item returns one derivative on the m_t* channel by way of the states ST_RD
// and ST_ROUT; it waits in ST_ROUT while the output register is still held by the receiver.
// A connection item walks every cell in use and then folds the per-cell sums into
// the derivative store. In conductance mode each cell passes through the 32-step
// remainder unit that wraps the whole shift plus the shared multiplier steps; in
// fixed mode the shift is worked out once and each further cell is paced by the
// shared multiplier and the three read-modify-write passes on the delta RAM. The
// fold then reads and writes back each cell in turn (ST_FRD, then ST_FWR).
// The block takes one item at a time; s_tready is high only while it is idle.
// After reset a clearing sweep writes zero to every derivative and delta entry,
// one entry a cycle, and s_tready stays low meanwhile.
// Configuration writes on cfg_we are taken at any time; they are meant for idle.
// A stalled receiver holds the result in the output register; a following read
// item waits for it, while loads and connections go on.
module grid_mass_shift_derivative #(
	parameter int MAX_CELLS = gmsd_pkg::MAX_CELLS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration write port.
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [31:0]                cfg_data,
	// Input items. tdata from bit 0: cell_index, mass, voltage, rate,
	// use_conductance, efficacy, rest_voltage, conductance, zero fill.
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [gmsd_pkg::IN_W-1:0]  s_tdata,
	// tuser: kind.
	input  logic [1:0]                 s_tuser,
	// Result items. tdata from bit 0: derivative, read_index, zero fill.
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [gmsd_pkg::OUT_W-1:0] m_tdata
);
	import gmsd_pkg::*;

	localparam int AW = $clog2(MAX_CELLS);
	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int DW = 42 + AW;

	localparam logic signed [DW:0] SAT_HI = (DW+1)'((64'sd1 <<< 47) - 64'sd1);
	localparam logic signed [DW:0] SAT_LO = -SAT_HI - (DW+1)'(1);

	localparam logic [4:0] ST_CLEAR = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_RD    = 5'd2;
	localparam logic [4:0] ST_ROUT  = 5'd3;
	localparam logic [4:0] ST_CRD   = 5'd4;
	localparam logic [4:0] ST_CDIFF = 5'd5;
	localparam logic [4:0] ST_CP    = 5'd6;
	localparam logic [4:0] ST_CHI   = 5'd7;
	localparam logic [4:0] ST_CLO   = 5'd8;
	localparam logic [4:0] ST_CMAG  = 5'd9;
	localparam logic [4:0] ST_CSH   = 5'd10;
	localparam logic [4:0] ST_CSHI  = 5'd11;
	localparam logic [4:0] ST_CMOD  = 5'd12;
	localparam logic [4:0] ST_CMASS = 5'd13;
	localparam logic [4:0] ST_CM    = 5'd14;
	localparam logic [4:0] ST_CGL   = 5'd15;
	localparam logic [4:0] ST_CGH   = 5'd16;
	localparam logic [4:0] ST_CGP   = 5'd17;
	localparam logic [4:0] ST_S1R   = 5'd18;
	localparam logic [4:0] ST_S1W   = 5'd19;
	localparam logic [4:0] ST_S2R   = 5'd20;
	localparam logic [4:0] ST_S2W   = 5'd21;
	localparam logic [4:0] ST_S3R   = 5'd22;
	localparam logic [4:0] ST_S3W   = 5'd23;
	localparam logic [4:0] ST_FRD   = 5'd24;
	localparam logic [4:0] ST_FWR   = 5'd25;

	logic [4:0] state_q;

	// Configuration registers.
	logic [10:0] cell_count_q;
	logic [31:0] inv_q;

	// Fields of the item under work.
	logic [9:0]  idx_q;
	logic [31:0] rate_q;
	logic        cond_q;
	logic [31:0] fixed_q;
	logic [31:0] rest_q;
	logic [31:0] g_q;

	// Per-cell datapath registers.
	logic [AW-1:0] j_q;
	logic [24:0]   mass_q;
	logic          neg_q;
	logic [32:0]   absd_q;
	logic [31:0]   lo_q;
	logic [51:0]   a_q;
	logic [31:0]   mag_q;
	logic          pos_q;
	logic [15:0]   frac_q;
	logic [CW-1:0] off_q;
	logic [39:0]   m_q;
	logic [47:0]   lo_prod_q;
	logic [39:0]   gp_q;
	logic [39:0]   sp_q;
	logic [AW-1:0] d1_q;
	logic [AW-1:0] d2_q;

	// Output register.
	logic          out_valid_q;
	logic [47:0]   out_der_q;
	logic [9:0]    out_idx_q;

	// Input field views.
	logic [9:0]  in_idx;
	logic [24:0] in_mass;
	logic [31:0] in_volt;
	logic        accept;
	logic        in_range;

	assign in_idx  = s_tdata[OFS_IDX +: 10];
	assign in_mass = s_tdata[OFS_MASS +: 25];
	assign in_volt = s_tdata[OFS_VOLT +: 32];
	assign accept  = s_tvalid && s_tready;
	assign in_range = 32'(in_idx) < 32'(MAX_CELLS);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_idx_q, out_der_q};

	// Cell count in use, held to the range of the store.
	logic [CW-1:0] n_act;
	logic          last_cell;

	always_comb begin
		if (cell_count_q == 11'd0) begin
			n_act = CW'(1);
		end else if (32'(cell_count_q) > 32'(MAX_CELLS)) begin
			n_act = CW'(MAX_CELLS);
		end else begin
			n_act = CW'(cell_count_q);
		end
	end

	assign last_cell = (CW'(j_q) == n_act - CW'(1));

	// Stores.
	logic [24:0]   mass_rd;
	logic [31:0]   volt_rd;
	logic [47:0]   der_rd;
	logic [DW-1:0] delta_rd;
	logic          cell_we;
	logic          der_we;
	logic [AW-1:0] der_waddr;
	logic [47:0]   der_wdata;
	logic [AW-1:0] der_raddr;
	logic          delta_we;
	logic [AW-1:0] delta_waddr;
	logic [DW-1:0] delta_wdata;
	logic [AW-1:0] delta_raddr;

	assign cell_we = accept && (s_tuser == KIND_LOAD) && in_range;

	gmsd_ram #(.WIDTH(25), .DEPTH(MAX_CELLS)) u_mass_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (AW'(in_idx)),
		.wdata (in_mass),
		.raddr (j_q),
		.rdata (mass_rd)
	);

	gmsd_ram #(.WIDTH(32), .DEPTH(MAX_CELLS)) u_volt_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (AW'(in_idx)),
		.wdata (in_volt),
		.raddr (j_q),
		.rdata (volt_rd)
	);

	gmsd_ram #(.WIDTH(48), .DEPTH(MAX_CELLS)) u_der_ram (
		.clk   (clk),
		.we    (der_we),
		.waddr (der_waddr),
		.wdata (der_wdata),
		.raddr (der_raddr),
		.rdata (der_rd)
	);

	gmsd_ram #(.WIDTH(DW), .DEPTH(MAX_CELLS)) u_delta_ram (
		.clk   (clk),
		.we    (delta_we),
		.waddr (delta_waddr),
		.wdata (delta_wdata),
		.raddr (delta_raddr),
		.rdata (delta_rd)
	);

	// Shared multiplier and remainder unit.
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [2*MUL_W-1:0] prod;
	logic               mod_start;
	logic               mod_busy;
	logic [CW-1:0]      mod_rem;

	gmsd_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	assign mod_start = (state_q == ST_CSHI);

	gmsd_mod #(.CW(CW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (prod[63:32]),
		.divisor  (n_act),
		.busy_q   (mod_busy),
		.rem_q    (mod_rem)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_CP: begin
				mul_a = {1'b0, g_q};
				mul_b = absd_q;
			end
			ST_CHI: begin
				mul_a = prod[64:32];
				mul_b = MUL_W'(TENTH_MILLI);
			end
			ST_CLO: begin
				mul_a = {1'b0, lo_q};
				mul_b = MUL_W'(TENTH_MILLI);
			end
			ST_CSH: begin
				mul_a = {1'b0, mag_q};
				mul_b = {1'b0, inv_q};
			end
			ST_CMASS: begin
				mul_a = {1'b0, rate_q};
				mul_b = MUL_W'(mass_q);
			end
			ST_CGL: begin
				mul_a = {1'b0, m_q[31:0]};
				mul_b = MUL_W'(frac_q);
			end
			ST_CGH: begin
				mul_a = MUL_W'(m_q[39:32]);
				mul_b = MUL_W'(frac_q);
			end
			default: begin
			end
		endcase
	end

	// Difference to the rest voltage, and the fixed efficacy magnitude.
	logic signed [32:0] diff;
	logic [32:0]        diff_abs;
	logic [31:0]        fixed_abs;

	assign diff      = $signed({rest_q[31], rest_q}) - $signed({volt_rd[31], volt_rd});
	assign diff_abs  = diff[32] ? 33'(-diff) : 33'(diff);
	assign fixed_abs = fixed_q[31] ? (32'd0 - fixed_q) : fixed_q;

	// Conductance magnitude: rounded scale to Q16.16 and clamp.
	logic [51:0] t_lo;
	logic [52:0] mag_sum;
	logic [36:0] mag_full;
	logic [31:0] mag_clamp;

	assign t_lo     = prod[51:0] + (52'd1 << 47);
	assign mag_sum  = {1'b0, a_q} + 53'(t_lo[51:32]);
	assign mag_full = mag_sum[52:16];

	always_comb begin
		if (neg_q) begin
			mag_clamp = (mag_full > 37'h0_8000_0000) ? 32'h8000_0000 : mag_full[31:0];
		end else begin
			mag_clamp = (mag_full > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag_full[31:0];
		end
	end

	// Mass flow and goes part.
	logic [56:0] m_sum;
	logic [55:0] mf;
	logic [56:0] g_sum;
	logic [39:0] gp_next;

	assign m_sum   = prod[56:0] + 57'h8000;
	assign mf      = {prod[23:0], 32'd0} + 56'(lo_prod_q);
	assign g_sum   = 57'(mf) + 57'h8000;
	assign gp_next = g_sum[55:16];

	// Target cells, wrapped around the cells in use.
	logic [CW:0]   fwd;
	logic [CW-1:0] d1_next;
	logic [CW-1:0] d2_next;

	always_comb begin
		fwd = {1'b0, CW'(j_q)} + {1'b0, off_q};
		if (pos_q) begin
			if (fwd >= {1'b0, n_act}) begin
				d1_next = CW'(fwd - {1'b0, n_act});
			end else begin
				d1_next = fwd[CW-1:0];
			end
			d2_next = (d1_next + CW'(1) == n_act) ? '0 : d1_next + CW'(1);
		end else begin
			if (CW'(j_q) >= off_q) begin
				d1_next = CW'(j_q) - off_q;
			end else begin
				d1_next = CW'(j_q) + n_act - off_q;
			end
			d2_next = (d1_next == '0) ? n_act - CW'(1) : d1_next - CW'(1);
		end
	end

	// Saturating fold of one cell's sum into its derivative.
	logic signed [DW:0] fold_sum;
	logic [47:0]        fold_sat;

	assign fold_sum = $signed({{(DW+1-48){der_rd[47]}}, der_rd})
		+ $signed({delta_rd[DW-1], delta_rd});

	always_comb begin
		if (fold_sum > SAT_HI) begin
			fold_sat = 48'h7FFF_FFFF_FFFF;
		end else if (fold_sum < SAT_LO) begin
			fold_sat = 48'h8000_0000_0000;
		end else begin
			fold_sat = fold_sum[47:0];
		end
	end

	// Store port selection.
	always_comb begin
		der_we    = 1'b0;
		der_waddr = j_q;
		der_wdata = '0;
		der_raddr = j_q;
		if (state_q == ST_RD || state_q == ST_ROUT) begin
			der_raddr = AW'(idx_q);
		end
		if (state_q == ST_CLEAR) begin
			der_we = 1'b1;
		end else if (state_q == ST_FWR) begin
			der_we    = 1'b1;
			der_wdata = fold_sat;
		end else if (cell_we) begin
			der_we    = 1'b1;
			der_waddr = AW'(in_idx);
		end
	end

	always_comb begin
		delta_we    = 1'b0;
		delta_waddr = j_q;
		delta_wdata = '0;
		delta_raddr = j_q;
		case (state_q)
			ST_CLEAR, ST_FWR: begin
				delta_we = 1'b1;
			end
			ST_S1R: begin
				delta_raddr = d1_q;
			end
			ST_S1W: begin
				delta_raddr = d1_q;
				delta_we    = 1'b1;
				delta_waddr = d1_q;
				delta_wdata = delta_rd + DW'(sp_q);
			end
			ST_S2R: begin
				delta_raddr = d2_q;
			end
			ST_S2W: begin
				delta_raddr = d2_q;
				delta_we    = 1'b1;
				delta_waddr = d2_q;
				delta_wdata = delta_rd + DW'(gp_q);
			end
			ST_S3W: begin
				delta_we    = 1'b1;
				delta_wdata = delta_rd - DW'(m_q);
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			j_q          <= '0;
			cell_count_q <= CELL_COUNT_RST;
			inv_q        <= INV_WIDTH_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CELL_COUNT: cell_count_q <= cfg_data[10:0];
					CFG_INV_WIDTH:  inv_q        <= cfg_data;
					default: begin
					end
				endcase
			end
			// A new result may replace the one taken by the receiver in the same cycle.
			if (state_q == ST_ROUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (j_q == AW'(MAX_CELLS - 1)) begin
						j_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == KIND_CONN) begin
							j_q     <= '0;
							state_q <= ST_CRD;
						end else if (s_tuser == KIND_READ) begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: state_q <= ST_ROUT;
				ST_ROUT: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CRD: state_q <= ST_CDIFF;
				ST_CDIFF: begin
					if (cond_q) begin
						state_q <= ST_CP;
					end else if (j_q == '0) begin
						state_q <= ST_CSH;
					end else begin
						state_q <= ST_CMASS;
					end
				end
				ST_CP:   state_q <= ST_CHI;
				ST_CHI:  state_q <= ST_CLO;
				ST_CLO:  state_q <= ST_CMAG;
				ST_CMAG: state_q <= ST_CSH;
				ST_CSH:  state_q <= ST_CSHI;
				ST_CSHI: state_q <= ST_CMOD;
				ST_CMOD: begin
					if (!mod_busy) begin
						state_q <= ST_CMASS;
					end
				end
				ST_CMASS: state_q <= ST_CM;
				ST_CM:    state_q <= ST_CGL;
				ST_CGL:   state_q <= ST_CGH;
				ST_CGH:   state_q <= ST_CGP;
				ST_CGP:   state_q <= ST_S1R;
				ST_S1R:   state_q <= ST_S1W;
				ST_S1W:   state_q <= ST_S2R;
				ST_S2R:   state_q <= ST_S2W;
				ST_S2W:   state_q <= ST_S3R;
				ST_S3R:   state_q <= ST_S3W;
				ST_S3W: begin
					if (last_cell) begin
						j_q     <= '0;
						state_q <= ST_FRD;
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= ST_CRD;
					end
				end
				ST_FRD: state_q <= ST_FWR;
				ST_FWR: begin
					if (last_cell) begin
						j_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= ST_FRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= in_idx;
			rate_q  <= s_tdata[OFS_RATE +: 32];
			cond_q  <= s_tdata[OFS_COND];
			fixed_q <= s_tdata[OFS_EFF +: 32];
			rest_q  <= s_tdata[OFS_REST +: 32];
			g_q     <= s_tdata[OFS_G +: 32];
		end
		case (state_q)
			ST_CDIFF: begin
				mass_q <= mass_rd;
				if (cond_q) begin
					neg_q  <= diff[32];
					absd_q <= diff_abs;
				end else begin
					neg_q <= fixed_q[31];
					mag_q <= fixed_abs;
				end
			end
			ST_CHI: lo_q <= prod[31:0];
			ST_CLO: a_q <= prod[51:0];
			ST_CMAG: mag_q <= mag_clamp;
			ST_CSHI: begin
				frac_q <= prod[31:16];
				pos_q  <= !neg_q && (mag_q != 32'd0);
			end
			ST_CMOD: off_q <= mod_rem;
			ST_CM: m_q <= m_sum[55:16];
			ST_CGH: lo_prod_q <= prod[47:0];
			ST_CGP: begin
				gp_q <= gp_next;
				sp_q <= m_q - gp_next;
				d1_q <= AW'(d1_next);
				d2_q <= AW'(d2_next);
			end
			ST_ROUT: begin
				if (!out_valid_q || m_tready) begin
					out_idx_q <= idx_q;
					out_der_q <= (32'(idx_q) < 32'(MAX_CELLS)) ? der_rd : 48'd0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/gmsd_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module gmsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/gmsd_mul.sv */
// Shared unsigned multiplier with a registered product.
module gmsd_mul (
	input  logic                         clk,
	input  logic [gmsd_pkg::MUL_W-1:0]   a,
	input  logic [gmsd_pkg::MUL_W-1:0]   b,
	output logic [2*gmsd_pkg::MUL_W-1:0] prod_q
);
	import gmsd_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

/* rtl/gmsd_mod.sv */
// Radix-2 restoring remainder unit: one dividend bit per cycle.
module gmsd_mod #(
	parameter int CW = 11
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [gmsd_pkg::DIVIDEND_W-1:0]   dividend,
	input  logic [CW-1:0]                     divisor,
	output logic                              busy_q,
	output logic [CW-1:0]                     rem_q
);
	import gmsd_pkg::*;

	localparam int SW = $clog2(DIVIDEND_W);

	logic [SW-1:0]         cnt_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [CW:0]           r_try;
	logic [CW:0]           r_next;

	always_comb begin
		r_try = {rem_q, dq_q[DIVIDEND_W-1]};
		if (r_try >= {1'b0, divisor}) begin
			r_next = r_try - {1'b0, divisor};
		end else begin
			r_next = r_try;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + SW'(1);
			if (cnt_q == SW'(DIVIDEND_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIVIDEND_W-2:0], 1'b0};
			rem_q <= r_next[CW-1:0];
		end
	end

endmodule
